@@ rtl/core/sgf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgf_pkg: shared definitions of the Savitzky-Golay record filter
// Widths, defaults, register indexes and the control word that the sequencer
// hands to the multiply-accumulate unit.
// ----------------------------------------------------------------------------
package sgf_pkg;

   localparam int MAX_TAPS_DEF     = 7;
   localparam int WINDOW_DEPTH_DEF = 16;
   localparam int SAMPLE_BITS_DEF  = 16;

   localparam int CNT_W       = 16;
   localparam int TAP_W       = 3;
   localparam int COEF_W      = 16;
   localparam int FRAC_BITS   = 14;
   localparam int MAX_RESULTS = 8;
   localparam int RES_W       = $clog2(MAX_RESULTS + 1);
   localparam int CSR_W       = 64;
   localparam int CSR_IDX_W   = 3;
   localparam int AGE_W       = CNT_W + 3;

   localparam logic [TAP_W-1:0] TAP_COUNT_RESET = 3'd5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TAP_COUNT  = 3'd0,
      CSR_DERIV_MODE = 3'd1,
      CSR_SMOOTH_LO  = 3'd2,
      CSR_SMOOTH_HI  = 3'd3,
      CSR_SLOPE_LO   = 3'd4,
      CSR_SLOPE_HI   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic clear;
      logic tap;
      logic zero;
      logic round;
   } mac_ctrl_type;

endpackage

@@ rtl/core/sgf_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgf_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sgf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/sgf_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgf_mac: shared multiply-accumulate unit
// One tap product per cycle into an accumulator; the sum keeps the 14 fraction
// bits of Q2.14 coefficients; it is rounded, then saturated to the sample range.
// ----------------------------------------------------------------------------
module sgf_mac import sgf_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int MAX_TAPS    = MAX_TAPS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mac_ctrl_type                  ctrl,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic signed [COEF_W-1:0]      coeff,
   output logic [SAMPLE_BITS-1:0]        filtered,
   output logic                          clipped
);

   localparam int PROD_W = SAMPLE_BITS + COEF_W;
   localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS);
   localparam int RND_W  = ACC_W + 1;

   localparam logic signed [RND_W-1:0] SAT_MAX =
      {{(RND_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [RND_W-1:0] SAT_MIN =
      {{(RND_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic                       prod_vld_ff;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [RND_W-1:0]    rnd, shifted, sat;
   logic                       clip;
   logic [SAMPLE_BITS-1:0]     filtered_ff;
   logic                       clipped_ff;

   always_comb begin
      if (ctrl.zero) begin
         prod_in = '0;
      end else begin
         prod_in = sample * coeff;
      end
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   // Round half up, then floor by the arithmetic shift.
   always_comb begin
      rnd     = RND_W'(acc_ff) + (RND_W'(1) << (FRAC_BITS - 1));
      shifted = rnd >>> FRAC_BITS;
      clip    = 1'b0;
      sat     = shifted;
      if (shifted > SAT_MAX) begin
         sat  = SAT_MAX;
         clip = 1'b1;
      end else if (shifted < SAT_MIN) begin
         sat  = SAT_MIN;
         clip = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= ctrl.tap;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (ctrl.round) begin
         filtered_ff <= sat[SAMPLE_BITS-1:0];
         clipped_ff  <= clip;
      end
   end

   assign filtered = filtered_ff;
   assign clipped  = clipped_ff;

endmodule

@@ rtl/core/savgol_fir_reflect_boundary.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// savgol_fir_reflect_boundary: streamed Savitzky-Golay FIR with mirrored edges
// Samples of a record enter on the req_ channel, tlast on the final one.
// Filtered values leave on the rsp_ channel, tlast on the last of a record and
// tuser set where the sum was saturated. The user writes coefficients and the
// tap count on the csr_ port only while the block is idle (not enforced).
// An accepted item is worked on alone: req_tready is low until every output it
// releases is computed. Each output walks the taps through one shared
// multiplier, one tap per cycle. The first live sample and the last sample
// of a record release several outputs (at most eight) back to back.
// An accepted item passes ST_EVAL, then ST_TAP for each tap, ST_DRAIN,
// ST_ROUND and ST_EMIT before its first output is loaded.
// A result waits in an output register; a stalled receiver holds it there.
// If the item has a next result, the sequencer waits with it in ST_EMIT,
// which keeps req_tready low until the held result is taken.
// Reset clears the counters, the window valid bits and the registers to their
// defaults (five taps, smoothing set, all coefficients zero).
// ----------------------------------------------------------------------------
module savgol_fir_reflect_boundary import sgf_pkg::*; #(
   parameter int MAX_TAPS     = MAX_TAPS_DEF,
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
   parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    req_tdata,  // sample
   input  logic                                req_tlast,  // end_of_record
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]    rsp_tdata,  // filtered
   output logic                                rsp_tlast,  // last_out
   output logic                                rsp_tuser,  // clipped
   input  logic                                csr_wr_en,
   input  logic [CSR_IDX_W-1:0]                csr_index,
   input  logic [CSR_W-1:0]                    csr_wdata
);

   localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int AW     = $clog2(WINDOW_DEPTH);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_EVAL  = 6'b000010,
      ST_TAP   = 6'b000100,
      ST_DRAIN = 6'b001000,
      ST_ROUND = 6'b010000,
      ST_EMIT  = 6'b100000
   } seq_state_type;

   seq_state_type state_ff, state_in;

   logic [TAP_W-1:0]      tap_count_ff;
   logic                  deriv_ff;
   logic [CSR_W-1:0]      smooth_lo_ff, smooth_hi_ff, slope_lo_ff, slope_hi_ff;

   logic [CNT_W-1:0]      rc_ff, rc_in, ec_ff, ec_in;
   logic                  live_ff, live_in;
   logic                  at_end_ff, at_end_in;
   logic [RES_W-1:0]      n_ff, n_in;
   logic [TAP_W-1:0]      tap_ff, tap_in;
   logic                  drain_ff, drain_in;
   logic [CNT_W-1:0]      rem_ff, rem_in, idx_ff, idx_in;
   logic                  last_ff, last_in;
   logic [AW-1:0]         head_ff, head_in, head_next;
   logic [WINDOW_DEPTH-1:0] valid_ff, valid_in;
   mac_ctrl_type          ctrl_ff, ctrl_in;
   logic [COEF_W-1:0]     coeff_ff, coeff_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_data_ff;
   logic                  rsp_last_ff, rsp_clip_ff;
   logic                  rsp_load;

   logic [TAP_W-1:0]      eff_taps, mid;
   logic [CNT_W-1:0]      pending, rc_inc;
   logic                  accept, emit_more;
   logic [2*CSR_W-1:0]    coeff_set;
   logic [COEF_W-1:0]     coeff_sel;

   logic signed [AGE_W-1:0] d_s, rem_s, i_s, pos_s, age_s;
   logic                  in_range;
   logic [AW-1:0]         age_lo, rd_addr;
   logic [AW:0]           addr_wrap;

   logic [SAMPLE_BITS-1:0] rd_data, mac_filtered;
   logic                  mac_clipped;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= TAP_COUNT_RESET;
         deriv_ff     <= 1'b0;
         smooth_lo_ff <= '0;
         smooth_hi_ff <= '0;
         slope_lo_ff  <= '0;
         slope_hi_ff  <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_TAP_COUNT:  tap_count_ff <= csr_wdata[TAP_W-1:0];
            CSR_DERIV_MODE: deriv_ff     <= csr_wdata[0];
            CSR_SMOOTH_LO:  smooth_lo_ff <= csr_wdata;
            CSR_SMOOTH_HI:  smooth_hi_ff <= csr_wdata;
            CSR_SLOPE_LO:   slope_lo_ff  <= csr_wdata;
            CSR_SLOPE_HI:   slope_hi_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Tap geometry
   // ------------------------------------------------------------------
   assign eff_taps = ({1'b0, tap_count_ff} > (TAP_W+1)'(MAX_TAPS)) ?
                     TAP_W'(MAX_TAPS) : tap_count_ff;
   assign mid      = eff_taps >> 1;
   assign pending  = rc_ff - ec_ff;
   assign rc_inc   = rc_ff + 1'b1;
   assign accept   = req_tvalid && req_tready;
   assign emit_more = live_ff && (n_ff < RES_W'(MAX_RESULTS)) && (pending != '0) &&
                      (at_end_ff || (pending > CNT_W'(mid)));
   assign head_next = (head_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : head_ff + 1'b1;

   assign coeff_set = deriv_ff ? {slope_hi_ff, slope_lo_ff} : {smooth_hi_ff, smooth_lo_ff};
   assign coeff_sel = coeff_set[tap_ff*COEF_W +: COEF_W];

   // Sample age of the current tap, mirrored at either end of the record.
   always_comb begin
      d_s   = $signed(AGE_W'(tap_ff)) - $signed(AGE_W'(mid));
      rem_s = $signed(AGE_W'(rem_ff));
      i_s   = $signed(AGE_W'(idx_ff));
      pos_s = i_s + d_s;
      if (at_end_ff && (d_s > rem_s)) begin
         age_s = d_s - rem_s - AGE_W'(1);
      end else if (pos_s[AGE_W-1]) begin
         age_s = (i_s <<< 1) + rem_s + d_s;
      end else begin
         age_s = rem_s - d_s;
      end
      in_range  = !age_s[AGE_W-1] && (age_s < $signed(AGE_W'(WINDOW_DEPTH)));
      age_lo    = age_s[AW-1:0];
      addr_wrap = {1'b0, head_ff} + (AW+1)'(WINDOW_DEPTH) - {1'b0, age_lo};
      rd_addr   = (head_ff >= age_lo) ? (head_ff - age_lo) : addr_wrap[AW-1:0];
   end

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in  = state_ff;
      rc_in     = rc_ff;
      ec_in     = ec_ff;
      live_in   = live_ff;
      at_end_in = at_end_ff;
      n_in      = n_ff;
      tap_in    = tap_ff;
      drain_in  = drain_ff;
      rem_in    = rem_ff;
      idx_in    = idx_ff;
      last_in   = last_ff;
      head_in   = head_ff;
      valid_in  = valid_ff;
      ctrl_in   = '0;
      coeff_in  = coeff_ff;
      rsp_load  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               head_in           = head_next;
               valid_in[head_next] = 1'b1;
               rc_in             = rc_inc;
               if (rc_inc > CNT_W'(eff_taps)) begin
                  live_in = 1'b1;
               end
               at_end_in = req_tlast;
               n_in      = '0;
               state_in  = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (emit_more) begin
               rem_in        = pending - 1'b1;
               idx_in        = ec_ff;
               last_in       = at_end_ff && (pending == CNT_W'(1));
               ctrl_in.clear = 1'b1;
               tap_in        = '0;
               drain_in      = 1'b0;
               state_in      = (eff_taps == '0) ? ST_DRAIN : ST_TAP;
            end else begin
               if (at_end_ff) begin
                  rc_in   = '0;
                  ec_in   = '0;
                  live_in = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         ST_TAP: begin
            ctrl_in.tap  = 1'b1;
            ctrl_in.zero = !in_range || !valid_ff[rd_addr];
            coeff_in     = coeff_sel;
            if (tap_ff == eff_taps - 1'b1) begin
               drain_in = 1'b0;
               state_in = ST_DRAIN;
            end else begin
               tap_in = tap_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            // Waiting here lets the last product pass the product register into the accumulator.
            if (drain_ff) begin
               ctrl_in.round = 1'b1;
               state_in      = ST_ROUND;
            end else begin
               drain_in = 1'b1;
            end
         end
         ST_ROUND: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               ec_in    = ec_ff + 1'b1;
               n_in     = n_ff + 1'b1;
               state_in = ST_EVAL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rc_ff        <= '0;
         ec_ff        <= '0;
         live_ff      <= 1'b0;
         at_end_ff    <= 1'b0;
         n_ff         <= '0;
         tap_ff       <= '0;
         drain_ff     <= 1'b0;
         head_ff      <= '0;
         valid_ff     <= '0;
         ctrl_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rc_ff        <= rc_in;
         ec_ff        <= ec_in;
         live_ff      <= live_in;
         at_end_ff    <= at_end_in;
         n_ff         <= n_in;
         tap_ff       <= tap_in;
         drain_ff     <= drain_in;
         head_ff      <= head_in;
         valid_ff     <= valid_in;
         ctrl_ff      <= ctrl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      idx_ff   <= idx_in;
      last_ff  <= last_in;
      coeff_ff <= coeff_in;
      if (rsp_load) begin
         rsp_data_ff <= mac_filtered;
         rsp_last_ff <= last_ff;
         rsp_clip_ff <= mac_clipped;
      end
   end

   // ------------------------------------------------------------------
   // Sample window and arithmetic
   // ------------------------------------------------------------------
   sgf_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (head_next),
      .wr_data (req_tdata[SAMPLE_BITS-1:0]),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sgf_mac #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_TAPS    (MAX_TAPS)
   ) u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl_ff),
      .sample   (rd_data),
      .coeff    (coeff_ff),
      .filtered (mac_filtered),
      .clipped  (mac_clipped)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'(rsp_data_ff);
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_clip_ff;

endmodule
